// ===== design/tvd_pkg.sv =====
// ----------------------------------------------------------------------------
// tvd_pkg
// Shared types and constants for the tagged value deserializer.
// ----------------------------------------------------------------------------
`default_nettype none

package tvd_pkg;

    localparam int ACC_WIDTH = 64;
    localparam int VALUE_WIDTH = 64;

    localparam logic [7:0] TAG_TRUE  = 8'h74;
    localparam logic [7:0] TAG_FALSE = 8'h66;
    localparam logic [7:0] TAG_CHAR  = 8'h63;
    localparam logic [7:0] TAG_SHORT = 8'h73;
    localparam logic [7:0] TAG_INT   = 8'h69;
    localparam logic [7:0] TAG_LONG  = 8'h6c;
    localparam logic [7:0] TAG_STR   = 8'h53;

    localparam logic [3:0] LONG_MAX_BYTES = 4'd8;

    typedef enum logic [2:0] {
        KIND_BOOL  = 3'd0,
        KIND_CHAR  = 3'd1,
        KIND_SHORT = 3'd2,
        KIND_INT   = 3'd3,
        KIND_LONG  = 3'd4,
        KIND_SLEN  = 3'd5,
        KIND_SCHAR = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_TAG       = 3'd1,
        ERR_SHORT     = 3'd2,
        ERR_INT       = 3'd3,
        ERR_LONG_SIZE = 3'd4
    } err_t;

    typedef struct packed {
        logic                    valid;
        kind_t                   kind;
        logic [VALUE_WIDTH-1:0]  value;
        err_t                    error;
    } tvd_result_t;

endpackage

`default_nettype wire

// ===== design/tvd_if.sv =====
// ----------------------------------------------------------------------------
// tvd_if
// Valid/ready channels for the byte stream and the decoded results.
// ----------------------------------------------------------------------------
`default_nettype none

interface tvd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface tvd_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [63:0] value;
    logic [2:0]  error;

    modport source (output valid, output kind, output value, output error, input ready);
    modport sink (input valid, input kind, input value, input error, output ready);
endinterface

`default_nettype wire

// ===== design/tagged_value_deserializer_top.sv =====
// ----------------------------------------------------------------------------
// tagged_value_deserializer_top
// Decodes a byte stream of tagged bools, chars, varints and strings.
// ----------------------------------------------------------------------------
// result: registered; it appears in the cycle after the byte that completes it
// throughput: one byte per cycle; the result register frees as it is taken
// a stalled result holds off the input until it is taken
// reset: asynchronous, active low; decoder waits for a tag, no result held
// ----------------------------------------------------------------------------
`default_nettype none

module tagged_value_deserializer_top (
    input  wire logic   clk,
    input  wire logic   rst_n,
    tvd_byte_if.sink    byte_in,
    tvd_result_if.source result_out
);
    import tvd_pkg::*;

    tvd_result_t res;
    tvd_result_t out_reg;
    logic        out_valid_reg;
    logic        fire;

    assign byte_in.ready = !out_valid_reg || result_out.ready;
    assign fire          = byte_in.valid && byte_in.ready;

    tvd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .data_byte (byte_in.data_byte),
        .result    (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res.valid)
            out_valid_reg <= 1'b1;
        else if (result_out.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
            out_reg <= res;
    end

    assign result_out.valid = out_valid_reg;
    assign result_out.kind  = out_reg.kind;
    assign result_out.value = out_reg.value;
    assign result_out.error = out_reg.error;

endmodule

`default_nettype wire

// ===== design/tvd_core.sv =====
// ----------------------------------------------------------------------------
// tvd_core
// Decode state and next-state logic; one stream byte per accepted beat.
// ----------------------------------------------------------------------------
`default_nettype none

module tvd_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                fire,
    input  wire logic [7:0]          data_byte,
    output tvd_pkg::tvd_result_t     result
);
    import tvd_pkg::*;

    typedef enum logic [1:0] {
        PH_TAG   = 2'd0,
        PH_HEAD  = 2'd1,
        PH_BODY  = 2'd2,
        PH_CHARS = 2'd3
    } phase_t;

    phase_t                 phase_reg, phase_next;
    kind_t                  kind_reg, kind_next;
    logic [3:0]             bytes_reg, bytes_next;
    logic [ACC_WIDTH-1:0]   acc_reg, acc_next;
    logic [31:0]            chars_reg, chars_next;
    logic                   finish;
    logic [VALUE_WIDTH-1:0] fin_value;
    tvd_result_t            step_res;

    assign fin_value = VALUE_WIDTH'($signed(acc_next));

    always_comb
    begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        bytes_next = bytes_reg;
        acc_next   = acc_reg;
        chars_next = chars_reg;
        finish     = 1'b0;
        step_res   = '{valid: 1'b0, kind: KIND_BOOL, value: '0, error: ERR_NONE};
        if (fire)
        begin
            unique case (phase_reg)
                PH_TAG:
                begin
                    unique case (data_byte)
                        TAG_TRUE:
                        begin
                            step_res.valid = 1'b1;
                            step_res.value = VALUE_WIDTH'(1);
                        end
                        TAG_FALSE: step_res.valid = 1'b1;
                        TAG_CHAR:
                        begin
                            kind_next  = KIND_CHAR;
                            phase_next = PH_HEAD;
                        end
                        TAG_SHORT:
                        begin
                            kind_next  = KIND_SHORT;
                            phase_next = PH_HEAD;
                        end
                        TAG_INT:
                        begin
                            kind_next  = KIND_INT;
                            phase_next = PH_HEAD;
                        end
                        TAG_LONG:
                        begin
                            kind_next  = KIND_LONG;
                            phase_next = PH_HEAD;
                        end
                        TAG_STR:
                        begin
                            kind_next  = KIND_SLEN;
                            phase_next = PH_HEAD;
                        end
                        default:
                        begin
                            step_res.valid = 1'b1;
                            step_res.error = ERR_TAG;
                        end
                    endcase
                end
                PH_HEAD:
                begin
                    if (kind_reg == KIND_CHAR)
                    begin
                        phase_next     = PH_TAG;
                        step_res.valid = 1'b1;
                        step_res.kind  = KIND_CHAR;
                        step_res.value = VALUE_WIDTH'(data_byte);
                    end
                    else if (kind_reg == KIND_LONG && data_byte[7:4] > LONG_MAX_BYTES)
                    begin
                        phase_next     = PH_TAG;
                        step_res.valid = 1'b1;
                        step_res.kind  = KIND_LONG;
                        step_res.error = ERR_LONG_SIZE;
                    end
                    else
                    begin
                        acc_next   = ACC_WIDTH'($signed(data_byte[3:0]));
                        bytes_next = data_byte[7:4];
                        if (data_byte[7:4] == 4'd0)
                            finish = 1'b1;
                        else
                            phase_next = PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    acc_next   = {acc_reg[ACC_WIDTH-9:0], data_byte};
                    bytes_next = bytes_reg - 4'd1;
                    if (bytes_next == 4'd0)
                        finish = 1'b1;
                end
                PH_CHARS:
                begin
                    if (chars_reg != 32'd0)
                        chars_next = chars_reg - 32'd1;
                    if (chars_next == 32'd0)
                        phase_next = PH_TAG;
                    step_res.valid = 1'b1;
                    step_res.kind  = KIND_SCHAR;
                    step_res.value = VALUE_WIDTH'(data_byte);
                end
                default: ;
            endcase
        end

        result = step_res;
        if (finish)
        begin
            phase_next   = PH_TAG;
            result.valid = 1'b1;
            result.kind  = kind_reg;
            result.value = fin_value;
            if (kind_reg == KIND_SHORT
                && !(&fin_value[VALUE_WIDTH-1:15] || ~|fin_value[VALUE_WIDTH-1:15]))
            begin
                result.value = '0;
                result.error = ERR_SHORT;
            end
            else if (kind_reg == KIND_INT
                && !(&fin_value[VALUE_WIDTH-1:31] || ~|fin_value[VALUE_WIDTH-1:31]))
            begin
                result.value = '0;
                result.error = ERR_INT;
            end
            else if (kind_reg == KIND_SLEN)
            begin
                if (fin_value[VALUE_WIDTH-1])
                    chars_next = 32'd0;
                else if (|fin_value[VALUE_WIDTH-2:32])
                    chars_next = '1;
                else
                    chars_next = fin_value[31:0];
                if (chars_next != 32'd0)
                    phase_next = PH_CHARS;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TAG;
            kind_reg  <= KIND_BOOL;
            bytes_reg <= '0;
            acc_reg   <= '0;
            chars_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            bytes_reg <= bytes_next;
            acc_reg   <= acc_next;
            chars_reg <= chars_next;
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives tagged byte streams into the deserializer and checks every decoded
// beat against an in-bench decoder: bools, chars, range-checked varints,
// oversize longs, strings of every length class, bad tags and back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import tvd_pkg::*;

    typedef enum logic [1:0] {
        WAIT_TAG   = 2'd0,
        WAIT_HEAD  = 2'd1,
        WAIT_BODY  = 2'd2,
        WAIT_CHARS = 2'd3
    } dec_phase_t;

    typedef struct packed {
        kind_t       kind;
        logic [63:0] value;
        err_t        error;
    } tvd_beat_t;

    localparam logic [63:0] ACC_MASK = {64{1'b1}} >> (64 - ACC_WIDTH);

    logic clk;
    logic rst_n;

    tvd_byte_if   byte_ch ();
    tvd_result_if result_ch ();

    tagged_value_deserializer_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_ch),
        .result_out (result_ch)
    );

    dec_phase_t  dec_phase;
    kind_t       dec_kind;
    logic [3:0]  body_left;
    logic [63:0] acc;
    logic [31:0] str_left;

    tvd_beat_t   pending_results[$];
    tvd_beat_t   want;
    int unsigned fail_count;
    int unsigned bytes_sent;
    int unsigned burst_left;
    bit          sender_steady;

    int unsigned hold_request;
    int unsigned hold_left;
    int unsigned stall_mode;
    int unsigned mode_left;
    int unsigned stall_phase;
    logic        ready_next;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic bit finish_value(output tvd_beat_t r);
        logic [63:0] v;
        longint      sv;
        v = acc & ACC_MASK;
        if (v[ACC_WIDTH-1])
        begin
            v = v | ~ACC_MASK;
        end
        sv = v;
        dec_phase = WAIT_TAG;
        r.kind = dec_kind;
        r.value = v;
        r.error = ERR_NONE;
        if (dec_kind == KIND_SHORT && (sv < -64'sd32768 || sv > 64'sd32767))
        begin
            r.value = '0;
            r.error = ERR_SHORT;
        end
        else if (dec_kind == KIND_INT &&
                 (sv < -64'sd2147483648 || sv > 64'sd2147483647))
        begin
            r.value = '0;
            r.error = ERR_INT;
        end
        else if (dec_kind == KIND_SLEN)
        begin
            if (v[63])
            begin
                str_left = '0;
            end
            else if (v > 64'hFFFF_FFFF)
            begin
                str_left = 32'hFFFF_FFFF;
            end
            else
            begin
                str_left = v[31:0];
            end
            if (str_left != 0)
            begin
                dec_phase = WAIT_CHARS;
            end
        end
        return 1'b1;
    endfunction

    function automatic bit decode_byte(input logic [7:0] b, output tvd_beat_t r);
        logic [3:0] cnt;
        cnt = b[7:4];
        r.kind = KIND_BOOL;
        r.value = '0;
        r.error = ERR_NONE;
        case (dec_phase)
            WAIT_TAG:
            begin
                case (b)
                    TAG_TRUE:
                    begin
                        r.value = 64'd1;
                        return 1'b1;
                    end
                    TAG_FALSE: return 1'b1;
                    TAG_CHAR:  dec_kind = KIND_CHAR;
                    TAG_SHORT: dec_kind = KIND_SHORT;
                    TAG_INT:   dec_kind = KIND_INT;
                    TAG_LONG:  dec_kind = KIND_LONG;
                    TAG_STR:   dec_kind = KIND_SLEN;
                    default:
                    begin
                        r.error = ERR_TAG;
                        return 1'b1;
                    end
                endcase
                dec_phase = WAIT_HEAD;
                return 1'b0;
            end
            WAIT_HEAD:
            begin
                if (dec_kind == KIND_CHAR)
                begin
                    dec_phase = WAIT_TAG;
                    r.kind = KIND_CHAR;
                    r.value = {56'd0, b};
                    return 1'b1;
                end
                if (dec_kind == KIND_LONG && cnt > LONG_MAX_BYTES)
                begin
                    dec_phase = WAIT_TAG;
                    r.kind = KIND_LONG;
                    r.error = ERR_LONG_SIZE;
                    return 1'b1;
                end
                acc = {{60{b[3]}}, b[3:0]} & ACC_MASK;
                body_left = cnt;
                if (cnt == 0)
                begin
                    return finish_value(r);
                end
                dec_phase = WAIT_BODY;
                return 1'b0;
            end
            WAIT_BODY:
            begin
                acc = ((acc << 8) | {56'd0, b}) & ACC_MASK;
                body_left = body_left - 4'd1;
                if (body_left == 0)
                begin
                    return finish_value(r);
                end
                return 1'b0;
            end
            default:
            begin
                if (str_left != 0)
                begin
                    str_left = str_left - 32'd1;
                end
                if (str_left == 0)
                begin
                    dec_phase = WAIT_TAG;
                end
                r.kind = KIND_SCHAR;
                r.value = {56'd0, b};
                return 1'b1;
            end
        endcase
    endfunction

    function automatic logic [63:0] rand_fit(input int unsigned cnt);
        longint      s;
        int unsigned keep;
        s = {$urandom, $urandom};
        keep = 8 * cnt + 4;
        if (keep < 64)
        begin
            s = (s <<< (64 - keep)) >>> (64 - keep);
        end
        return s;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        tvd_beat_t   r;
        if (!sender_steady && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap)
            begin
                @(negedge clk);
                byte_ch.valid <= 1'b0;
            end
        end
        if (burst_left != 0)
        begin
            burst_left--;
        end
        @(negedge clk);
        byte_ch.valid <= 1'b1;
        byte_ch.data_byte <= b;
        do
            @(posedge clk);
        while (!byte_ch.ready);
        if (decode_byte(b, r))
        begin
            pending_results.push_back(r);
        end
        bytes_sent++;
    endtask

    task automatic send_encoded(input logic [63:0] v, input int unsigned cnt);
        logic [3:0] nib;
        if (cnt >= 8)
        begin
            nib = {4{v[63]}};
        end
        else
        begin
            nib = v[8*cnt +: 4];
        end
        send_byte({4'(cnt), nib});
        for (int i = int'(cnt) - 1; i >= 0; i--)
        begin
            send_byte(v[8*i +: 8]);
        end
    endtask

    task automatic send_random_value();
        int unsigned pick;
        int unsigned len;
        longint      slen;
        logic [7:0]  bad;
        pick = $urandom_range(0, 99);
        if (pick < 6)
        begin
            // unknown tags only, so the stream stays framed
            bad = 8'($urandom);
            while (bad == TAG_TRUE || bad == TAG_FALSE || bad == TAG_CHAR
                   || bad == TAG_SHORT || bad == TAG_INT || bad == TAG_LONG
                   || bad == TAG_STR)
            begin
                bad = 8'($urandom);
            end
            send_byte(bad);
        end
        else if (pick < 14)
        begin
            send_byte(($urandom_range(0, 1) != 0) ? TAG_TRUE : TAG_FALSE);
        end
        else if (pick < 24)
        begin
            send_byte(TAG_CHAR);
            send_byte(8'($urandom));
        end
        else if (pick < 40)
        begin
            len = $urandom_range(0, 3);
            send_byte(TAG_SHORT);
            send_encoded(rand_fit(len), len);
        end
        else if (pick < 56)
        begin
            len = $urandom_range(0, 5);
            send_byte(TAG_INT);
            send_encoded(rand_fit(len), len);
        end
        else if (pick < 76)
        begin
            send_byte(TAG_LONG);
            if ($urandom_range(0, 9) == 0)
            begin
                send_byte({4'($urandom_range(9, 15)), 4'($urandom)});
            end
            else
            begin
                len = $urandom_range(0, 8);
                send_encoded(rand_fit(len), len);
            end
        end
        else
        begin
            send_byte(TAG_STR);
            if ($urandom_range(0, 9) == 0)
            begin
                slen = -longint'($urandom_range(1, 300));
            end
            else
            begin
                slen = $urandom_range(0, 6);
            end
            send_encoded(slen, (slen < -8 || slen > 7) ? 2 : $urandom_range(0, 1));
            for (longint i = 0; i < slen; i++)
            begin
                send_byte(8'($urandom));
            end
        end
    endtask

    task automatic sync_to_tag();
        while (dec_phase != WAIT_TAG)
        begin
            send_byte(8'($urandom));
        end
    endtask

    task automatic test_bools_and_bad_tags();
        send_byte(TAG_TRUE);
        send_byte(TAG_FALSE);
        send_byte(8'hFF);
        send_byte(8'h00);
    endtask

    task automatic test_char();
        send_byte(TAG_CHAR);
        send_byte(8'hFF);
    endtask

    task automatic test_short_range();
        send_byte(TAG_SHORT);
        send_encoded(-64'sd32768, 2);
        send_byte(TAG_SHORT);
        send_encoded(64'sd32768, 2);
    endtask

    task automatic test_int_range();
        send_byte(TAG_INT);
        send_encoded(64'sd2147483648, 4);
    endtask

    task automatic test_long_header();
        // oversize header, then a count-zero header carrying a negative nibble
        send_byte(TAG_LONG);
        send_byte(8'h90);
        send_byte(TAG_LONG);
        send_byte(8'h08);
    endtask

    task automatic test_string_lengths();
        send_byte(TAG_STR);
        send_byte(8'h0F);
        send_byte(TAG_STR);
        send_byte(8'h00);
        send_byte(TAG_STR);
        send_byte(8'h01);
        send_byte(8'h5A);
    endtask

    task automatic test_random_stream(input int unsigned upto);
        while (bytes_sent < upto)
        begin
            send_random_value();
        end
    endtask

    task automatic test_result_backpressure();
        sync_to_tag();
        sender_steady = 1'b1;
        hold_request = 120;
        repeat (30)
        begin
            send_random_value();
        end
        sender_steady = 1'b0;
    endtask

    task automatic test_huge_string();
        // length saturates, so every later beat is a string char
        sync_to_tag();
        send_byte(TAG_STR);
        send_encoded(64'h1_0000_0000, 5);
        repeat (16)
        begin
            send_byte(8'($urandom));
        end
    endtask

    always @(negedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(16, 96);
        end
        else
        begin
            mode_left--;
        end
        stall_phase++;
        if (hold_left != 0)
        begin
            hold_left--;
            ready_next = 1'b0;
        end
        else
        begin
            case (stall_mode)
                0:       ready_next = 1'b1;
                1:       ready_next = ($urandom_range(0, 3) != 0);
                2:       ready_next = ($urandom_range(0, 3) == 0);
                default: ready_next = (stall_phase % 5 < 3);
            endcase
        end
        result_ch.ready <= ready_next;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected beat kind=%0d value=%h error=%0d",
                       result_ch.kind, result_ch.value, result_ch.error);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_ch.kind !== want.kind)
                begin
                    $error("kind: expected %0d, actual %0d", want.kind, result_ch.kind);
                    fail_count++;
                end
                if (result_ch.value !== want.value)
                begin
                    $error("value: expected %h, actual %h", want.value, result_ch.value);
                    fail_count++;
                end
                if (result_ch.error !== want.error)
                begin
                    $error("error: expected %0d, actual %0d", want.error, result_ch.error);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        byte_ch.valid = 1'b0;
        byte_ch.data_byte = 8'h00;
        result_ch.ready = 1'b0;
        dec_phase = WAIT_TAG;
        dec_kind = KIND_BOOL;
        body_left = '0;
        acc = '0;
        str_left = '0;
        fail_count = 0;
        bytes_sent = 0;
        burst_left = 0;
        sender_steady = 1'b0;
        hold_request = 0;
        hold_left = 0;
        stall_mode = 0;
        mode_left = 0;
        stall_phase = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_bools_and_bad_tags();
        test_char();
        test_short_range();
        test_int_range();
        test_long_header();
        test_string_lengths();
        test_random_stream(300);
        test_result_backpressure();
        test_random_stream(520);
        test_huge_string();

        @(negedge clk);
        byte_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/tvd_pkg.sv
design/tvd_if.sv
design/tvd_core.sv
design/tagged_value_deserializer_top.sv
tb/tb_top.sv
